/* sv/ssis_pkg.sv */
package ssis_pkg;

	// Width of the start position register and of the configuration data
	localparam int START_W = 12;

	// Width of the register index on the configuration port
	localparam int IDX_W = 2;

	// Register indexes
	localparam logic [IDX_W-1:0] CFG_DIRECTION = 2'd0;
	localparam logic [IDX_W-1:0] CFG_FILL      = 2'd1;
	localparam logic [IDX_W-1:0] CFG_START     = 2'd2;

	// Direction codes
	localparam logic DIR_STRIP  = 1'b0;
	localparam logic DIR_INSERT = 1'b1;

	// Status fill codes for even slots
	localparam logic [1:0] FILL_IDLE    = 2'd0;
	localparam logic [1:0] FILL_BUSY    = 2'd1;
	localparam logic [1:0] FILL_UNKNOWN = 2'd2;

	// Most status bits sent ahead of one payload bit
	localparam logic [1:0] MAX_STATUS = 2'd2;

	typedef struct packed {
		logic       direction;
		logic [1:0] status_fill;
	} cfg_t;

	typedef struct packed {
		logic out_bit;
		logic is_status;
		logic last_of_run;
	} result_t;

	// Value of one status bit: odd slots and unused fill codes carry unknown (1,0)
	function automatic logic status_bit(input logic [1:0] fill, input logic odd,
			input logic second);
		logic b0;
		logic b1;
		b0 = 1'b1;
		b1 = 1'b0;
		if (!odd) begin
			case (fill)
				FILL_IDLE: begin
					b0 = 1'b1;
					b1 = 1'b1;
				end
				FILL_BUSY: begin
					b0 = 1'b0;
					b1 = 1'b1;
				end
				default: begin
					b0 = 1'b1;
					b1 = 1'b0;
				end
			endcase
		end
		return second ? b1 : b0;
	endfunction

endpackage

/* sv/ssis_div.sv */
// Remainder and quotient parity of a division by a constant, by reciprocal
// multiplication: the product with the scaled reciprocal is registered first,
// then the quotient is taken from its upper bits and multiplied back to form the
// remainder. The reciprocal is exact for every NW-bit dividend.
module ssis_div #(
	parameter int DIVISOR = 72,
	parameter int NW      = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] rem,
	output logic          qlsb
);

	localparam int     LW    = $clog2(DIVISOR);
	localparam int     SH    = NW + LW;
	localparam int     MW    = NW + 2;
	localparam int     PRW   = NW + MW;
	localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - 1) /
			longint'(DIVISOR);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
	localparam logic [NW-1:0] DIV_N   = NW'(DIVISOR);

	logic [NW-1:0]  x_s1;
	logic [PRW-1:0] prod_s1;
	logic           busy_q;
	logic           done_q;
	logic [NW-1:0]  rem_q;
	logic           qlsb_q;

	logic [NW-1:0]  quo;
	logic [NW-1:0]  back;
	logic [NW-1:0]  rem_d;

	// Take the quotient from the product and form the remainder
	always_comb begin
		quo   = NW'(prod_s1 >> SH);
		back  = quo * DIV_N;
		rem_d = x_s1 - back;
	end

	// Advance the control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	// Hold the dividend and its product, then the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			x_s1    <= dividend;
			prod_s1 <= PRW'(dividend) * PRW'(RECIP_M);
		end
		if (busy_q) begin
			rem_q  <= rem_d;
			qlsb_q <= quo[0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;
	assign qlsb = qlsb_q;

endmodule

/* sv/ssis_engine.sv */
// Input register, frame position tracker and result register.
module ssis_engine #(
	parameter int STATUS_FIRST   = 70,
	parameter int STATUS_PERIOD  = 72,
	parameter int FRAME_BITS_MAX = 4096,
	parameter int PW             = 12,
	parameter int HW             = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssis_pkg::cfg_t        cfg,
	input  logic                  hold,
	input  logic                  reload,
	input  logic [PW-1:0]         start_pos,
	input  logic [HW-1:0]         start_phase,
	input  logic                  start_odd,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_bit,
	input  logic                  in_last,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ssis_pkg::result_t     res
);

	localparam int CW = (PW + 1 > ssis_pkg::START_W + 1) ? PW + 1 : ssis_pkg::START_W + 1;
	localparam logic [HW-1:0] RST_PHASE = (STATUS_FIRST == 0) ? HW'(0) : HW'(STATUS_PERIOD);

	logic            valid_s1;
	logic            bit_s1;
	logic            last_s1;
	logic [PW-1:0]   pos_q;
	logic [HW-1:0]   phase_q;
	logic            odd_q;
	logic [1:0]      nst_q;
	logic            res_valid_q;
	ssis_pkg::result_t res_q;

	logic            strip;
	logic            at_status;
	logic            ins_status;
	logic            emit;
	logic            out_free;
	logic            step;
	logic            consume;
	ssis_pkg::result_t res_d;
	logic [PW:0]     nxt;
	logic [CW-1:0]   nxt_ext;
	logic [PW-1:0]   adv_pos;
	logic [HW-1:0]   adv_phase;
	logic            adv_odd;

	// Decide what this cycle does with the held item
	always_comb begin
		strip      = cfg.direction == ssis_pkg::DIR_STRIP;
		at_status  = (phase_q == HW'(0)) || (phase_q == HW'(1));
		ins_status = !strip && at_status && (nst_q < ssis_pkg::MAX_STATUS);
		emit       = valid_s1 && (strip ? !at_status : 1'b1);
		out_free   = !res_valid_q || res_ready;
		step       = valid_s1 && (!emit || out_free);
		consume    = step && (strip || !ins_status);
		in_ready   = !hold && (!valid_s1 || consume);
		if (ins_status) begin
			res_d.out_bit     = ssis_pkg::status_bit(cfg.status_fill, odd_q,
					phase_q == HW'(1));
			res_d.is_status   = 1'b1;
			res_d.last_of_run = 1'b0;
		end else begin
			res_d.out_bit     = bit_s1;
			res_d.is_status   = 1'b0;
			res_d.last_of_run = 1'b1;
		end
	end

	// Advance the frame position by one bit
	always_comb begin
		nxt       = {1'b0, pos_q} + 1'b1;
		nxt_ext   = CW'(nxt);
		adv_pos   = nxt[PW-1:0];
		adv_phase = phase_q;
		adv_odd   = odd_q;
		if (nxt == (PW+1)'(FRAME_BITS_MAX)) begin
			adv_pos   = '0;
			adv_phase = RST_PHASE;
			adv_odd   = 1'b0;
		end else if (nxt_ext < CW'(STATUS_FIRST)) begin
			adv_phase = HW'(STATUS_PERIOD);
			adv_odd   = 1'b0;
		end else if (nxt_ext == CW'(STATUS_FIRST)) begin
			adv_phase = '0;
			adv_odd   = 1'b0;
		end else if (phase_q == HW'(STATUS_PERIOD - 1)) begin
			adv_phase = '0;
			adv_odd   = !odd_q;
		end else begin
			adv_phase = phase_q + 1'b1;
		end
	end

	// Track the frame position; restart it on a reload or after the last input of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= RST_PHASE;
			odd_q   <= 1'b0;
			nst_q   <= '0;
		end else begin
			if (reload || (consume && last_s1)) begin
				pos_q   <= start_pos;
				phase_q <= start_phase;
				odd_q   <= start_odd;
			end else if (step) begin
				pos_q   <= adv_pos;
				phase_q <= adv_phase;
				odd_q   <= adv_odd;
			end
			if (consume) begin
				nst_q <= '0;
			end else if (step && ins_status) begin
				nst_q <= nst_q + 1'b1;
			end
		end
	end

	// Hold the accepted input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bit_s1  <= in_bit;
			last_s1 <= in_last;
		end
	end

	// Hold the result until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* sv/status_symbol_insert_strip.sv */
// Status bit insertion and removal for a bit-serial frame stream. In strip mode
// (direction 0) one frame bit is taken per cycle while the output is not stalled,
// and bits at status positions are dropped. In insert mode (direction 1) one
// payload bit is taken per cycle under the same condition unless a status pair is
// due: the pair goes out first, one bit per cycle through the single result
// register. Even slots carry the configured fill, odd slots unknown (1,0). An
// input with tlast restarts the frame at start_position. Writing start_position
// holds off input while two constant dividers reduce the start position modulo
// the frame length and then, unless it lies ahead of the first status pair, its
// offset from STATUS_FIRST modulo the status period.
module status_symbol_insert_strip #(
	parameter int STATUS_FIRST   = 70,
	parameter int STATUS_PERIOD  = 72,
	parameter int FRAME_BITS_MAX = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ssis_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ssis_pkg::START_W-1:0]  cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] data_bit, [7:1] zero
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [0] out_bit, [7:1] zero
	output logic                          m_tuser,   // [0] is_status
	output logic                          m_tlast
);

	localparam int PW   = $clog2(FRAME_BITS_MAX);
	localparam int HW   = $clog2(STATUS_PERIOD + 1);
	localparam int SW   = ssis_pkg::START_W;
	localparam logic [HW-1:0] RST_PHASE = (STATUS_FIRST == 0) ? HW'(0) : HW'(STATUS_PERIOD);

	typedef enum logic [2:0] {
		SEQ_IDLE = 3'b001,
		SEQ_MODF = 3'b010,
		SEQ_MODP = 3'b100
	} seq_t;

	seq_t              seq_q;
	ssis_pkg::cfg_t    cfg_q;
	logic [PW-1:0]     start_pos_q;
	logic [HW-1:0]     start_phase_q;
	logic              start_odd_q;
	logic              ld_q;

	logic              kick_f;
	logic              kick_p;
	logic              ld_d;
	logic [SW-1:0]     p_dividend;
	logic              f_busy;
	logic              f_done;
	logic [SW-1:0]     f_rem;
	logic              f_qlsb;
	logic              p_busy;
	logic              p_done;
	logic [SW-1:0]     p_rem;
	logic              p_qlsb;
	logic [PW+SW-1:0]  rem_ext;
	logic [HW+SW-1:0]  phase_ext;
	logic [SW-1:0]     pos_red;
	logic              below_first;
	logic              hold;
	ssis_pkg::result_t res;

	// Select the divider operands and start strobes for each pass, and the input hold
	always_comb begin
		rem_ext     = {{PW{1'b0}}, f_rem};
		phase_ext   = {{HW{1'b0}}, p_rem};
		pos_red     = f_rem;
		below_first = pos_red < SW'(STATUS_FIRST);
		kick_f      = cfg_we && (cfg_index == ssis_pkg::CFG_START);
		kick_p      = (seq_q == SEQ_MODF) && f_done && !below_first && !kick_f;
		ld_d        = !kick_f && (((seq_q == SEQ_MODF) && f_done && below_first) ||
				((seq_q == SEQ_MODP) && p_done));
		p_dividend  = pos_red - SW'(STATUS_FIRST);
		hold        = (seq_q != SEQ_IDLE) || ld_q;
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction   <= ssis_pkg::DIR_STRIP;
			cfg_q.status_fill <= ssis_pkg::FILL_IDLE;
		end else if (cfg_we) begin
			if (cfg_index == ssis_pkg::CFG_DIRECTION) begin
				cfg_q.direction <= cfg_wdata[0];
			end
			if (cfg_index == ssis_pkg::CFG_FILL) begin
				cfg_q.status_fill <= cfg_wdata[1:0];
			end
		end
	end

	// Sequence the start position reduction and reload the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q         <= SEQ_IDLE;
			ld_q          <= 1'b0;
			start_pos_q   <= '0;
			start_phase_q <= RST_PHASE;
			start_odd_q   <= 1'b0;
		end else begin
			ld_q <= ld_d;
			if (kick_f) begin
				seq_q <= SEQ_MODF;
			end else begin
				unique case (seq_q)
					SEQ_IDLE: begin
						seq_q <= SEQ_IDLE;
					end
					SEQ_MODF: begin
						if (f_done) begin
							start_pos_q <= rem_ext[PW-1:0];
							if (below_first) begin
								start_phase_q <= HW'(STATUS_PERIOD);
								start_odd_q   <= 1'b0;
								seq_q         <= SEQ_IDLE;
							end else begin
								seq_q <= SEQ_MODP;
							end
						end
					end
					SEQ_MODP: begin
						if (p_done) begin
							start_phase_q <= phase_ext[HW-1:0];
							start_odd_q   <= p_qlsb;
							seq_q         <= SEQ_IDLE;
						end
					end
					default: begin
						seq_q <= SEQ_IDLE;
					end
				endcase
			end
		end
	end

	ssis_div #(
		.DIVISOR (FRAME_BITS_MAX),
		.NW      (SW)
	) u_div_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (kick_f),
		.dividend (cfg_wdata),
		.busy     (f_busy),
		.done     (f_done),
		.rem      (f_rem),
		.qlsb     (f_qlsb)
	);

	ssis_div #(
		.DIVISOR (STATUS_PERIOD),
		.NW      (SW)
	) u_div_period (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (kick_p),
		.dividend (p_dividend),
		.busy     (p_busy),
		.done     (p_done),
		.rem      (p_rem),
		.qlsb     (p_qlsb)
	);

	ssis_engine #(
		.STATUS_FIRST   (STATUS_FIRST),
		.STATUS_PERIOD  (STATUS_PERIOD),
		.FRAME_BITS_MAX (FRAME_BITS_MAX),
		.PW             (PW),
		.HW             (HW)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.hold        (hold),
		.reload      (ld_q),
		.start_pos   (start_pos_q),
		.start_phase (start_phase_q),
		.start_odd   (start_odd_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_bit      (s_tdata[0]),
		.in_last     (s_tlast),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res         (res)
	);

	assign m_tdata = {7'b0, res.out_bit};
	assign m_tuser = res.is_status;
	assign m_tlast = res.last_of_run;

	// No input transaction while the frame state is being reloaded
	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !s_tready)
		else $error("input accepted during start position reload");

	// An inserted status bit never ends the results of an input
	a_status_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> !m_tlast)
		else $error("status bit marked last");

	// The dividers only run while the sequencer waits for them
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SEQ_IDLE) |-> !(f_busy || p_busy))
		else $error("divider running with idle sequencer");

endmodule
